[sv/itoa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to ASCII text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_BITS = 64;
    localparam int MAX_CHARS  = 23;

    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam int IDX_W = $clog2(MAX_CHARS);

    localparam logic [4:0] BASE_MIN = 5'd8;
    localparam logic [4:0] BASE_MAX = 5'd16;

    localparam logic [7:0] MINUS_CHAR = 8'h2D;

    localparam logic [7:0] DIGIT_SET [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef struct packed {
        logic [63:0] value;
        logic [4:0]  radix;
        logic        is_signed;
    } t_in_word;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_STORE,
        S_SIGN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic store_sign;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic bit_done;
        logic quo_zero;
        logic last_slot;
        logic sign_due;
        logic out_free;
        logic emit_last;
    } t_dp_stat;

endpackage

[sv/itoa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: load, one divide per digit, optional sign, then emit.
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  itoa_pkg::t_dp_stat i_stat,
    output itoa_pkg::t_dp_cmd  o_cmd
);

    itoa_pkg::t_state r_state;
    itoa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itoa_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = itoa_pkg::S_DIVIDE;
                end
            end
            itoa_pkg::S_DIVIDE: begin
                if (i_stat.bit_done) begin
                    n_state = itoa_pkg::S_STORE;
                end
            end
            itoa_pkg::S_STORE: begin
                if (i_stat.quo_zero || i_stat.last_slot) begin
                    n_state = itoa_pkg::S_SIGN;
                end else begin
                    n_state = itoa_pkg::S_DIVIDE;
                end
            end
            itoa_pkg::S_SIGN: begin
                n_state = itoa_pkg::S_EMIT;
            end
            itoa_pkg::S_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = itoa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = itoa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            itoa_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            itoa_pkg::S_DIVIDE: begin
                o_cmd.step = 1'b1;
            end
            itoa_pkg::S_STORE: begin
                o_cmd.store = 1'b1;
            end
            itoa_pkg::S_SIGN: begin
                o_cmd.store_sign = i_stat.sign_due;
            end
            itoa_pkg::S_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTH
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itoa_pkg::S_EMIT && o_cmd.emit && i_stat.emit_last)
        |=> (r_state == itoa_pkg::S_IDLE))
        else $error("itoa_ctrl: no return to idle after final character");
`endif

endmodule

[sv/itoa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dp
// Bit-serial divider by the base, character buffer and output register.
// ----------------------------------------------------------------------------
module itoa_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itoa_pkg::t_in_word  i_data,
    input  itoa_pkg::t_dp_cmd   i_cmd,
    output itoa_pkg::t_dp_stat  o_stat,
    output itoa_pkg::t_out_word o_data,
    output logic                o_valid,
    input  logic                i_ready
);

    logic [itoa_pkg::VALUE_BITS-1:0] r_val;
    logic [itoa_pkg::VALUE_BITS-1:0] in_val;
    logic [itoa_pkg::VALUE_BITS-1:0] in_mag;
    logic                            in_neg;
    logic [4:0]                      in_base;
    logic [4:0]                      r_base;
    logic [3:0]                      r_rem;
    logic                            r_neg;
    logic [itoa_pkg::BIT_W-1:0]      r_bit;
    logic [itoa_pkg::CNT_W-1:0]      r_cnt;
    logic [itoa_pkg::CNT_W-1:0]      cnt_m1;
    logic [7:0]                      r_buf [itoa_pkg::MAX_CHARS];
    logic [4:0]                      rem_sh;
    logic                            q_bit;
    logic [4:0]                      rem_nx;
    itoa_pkg::t_out_word             r_out;
    logic                            r_ovalid;

    assign in_val = i_data.value[itoa_pkg::VALUE_BITS-1:0];
    assign in_neg = i_data.is_signed && in_val[itoa_pkg::VALUE_BITS-1];
    assign in_mag = in_neg ? (~in_val + 1'b1) : in_val;

    always_comb begin
        if (i_data.radix < itoa_pkg::BASE_MIN) begin
            in_base = itoa_pkg::BASE_MIN;
        end else if (i_data.radix > itoa_pkg::BASE_MAX) begin
            in_base = itoa_pkg::BASE_MAX;
        end else begin
            in_base = i_data.radix;
        end
    end

    // restoring divide, one quotient bit per cycle
    assign rem_sh = {r_rem, r_val[itoa_pkg::VALUE_BITS-1]};
    assign q_bit  = (rem_sh >= r_base);
    assign rem_nx = q_bit ? (rem_sh - r_base) : rem_sh;
    assign cnt_m1 = r_cnt - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= in_mag;
        end else if (i_cmd.step) begin
            r_val <= {r_val[itoa_pkg::VALUE_BITS-2:0], q_bit};
        end
        if (i_cmd.store) begin
            r_buf[r_cnt[itoa_pkg::IDX_W-1:0]] <= itoa_pkg::DIGIT_SET[r_rem];
        end else if (i_cmd.store_sign) begin
            r_buf[r_cnt[itoa_pkg::IDX_W-1:0]] <= itoa_pkg::MINUS_CHAR;
        end
        if (i_cmd.emit) begin
            r_out.character <= r_buf[cnt_m1[itoa_pkg::IDX_W-1:0]];
            r_out.last_char <= (r_cnt == itoa_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= itoa_pkg::BASE_MIN;
            r_rem    <= '0;
            r_neg    <= 1'b0;
            r_bit    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_base <= in_base;
                r_neg  <= in_neg;
                r_rem  <= '0;
                r_bit  <= '0;
                r_cnt  <= '0;
            end else if (i_cmd.step) begin
                r_rem <= rem_nx[3:0];
                r_bit <= r_bit + 1'b1;
            end else if (i_cmd.store) begin
                r_rem <= '0;
                r_bit <= '0;
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.store_sign) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.emit) begin
                r_cnt <= cnt_m1;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.bit_done  = (r_bit == itoa_pkg::BIT_W'(itoa_pkg::VALUE_BITS - 1));
    assign o_stat.quo_zero  = (r_val == '0);
    assign o_stat.last_slot = (r_cnt == itoa_pkg::CNT_W'(itoa_pkg::MAX_CHARS - 1));
    assign o_stat.sign_due  = r_neg && (r_cnt != itoa_pkg::CNT_W'(itoa_pkg::MAX_CHARS));
    assign o_stat.out_free  = !r_ovalid || i_ready;
    assign o_stat.emit_last = (r_cnt == itoa_pkg::CNT_W'(1));

    assign o_data  = r_out;
    assign o_valid = r_ovalid;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= itoa_pkg::CNT_W'(itoa_pkg::MAX_CHARS))
        else $error("itoa_dp: character count beyond buffer");
    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_rem} < r_base)
        else $error("itoa_dp: remainder not below base");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_cnt != '0))
        else $error("itoa_dp: emit from empty buffer");
    a_emit_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_stat.emit_last) |=> (r_cnt == '0) && o_data.last_char)
        else $error("itoa_dp: final character not marked");
`endif

endmodule

[sv/integer_to_ascii_radix_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top
// Converts a value to ASCII text in base 8 to 16, most significant first.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Word
// input    in         i_valid / o_ready   i_data : value, radix, is_signed
// output   out        o_valid / i_ready   o_data : character, last_char
//
// Each digit is formed in the shared bit-serial divider (one quotient bit
// per cycle), then stored in the character buffer.
// One item at a time; o_ready is high only while the block waits for input.
// The final character may still sit in the output register when the next
// word is taken. Output stalls hold the character buffer; reset is
// synchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  itoa_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output itoa_pkg::t_out_word o_data
);

    itoa_pkg::t_dp_cmd  cmd;
    itoa_pkg::t_dp_stat stat;

    itoa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    itoa_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_data  (o_data),
        .o_valid (o_valid),
        .i_ready (i_ready)
    );

endmodule
